### rtl/core/frsck_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frsck_pkg
// Shared types, register indexes and the byte-wide CRC-16 step for the
// frame sum / CRC-16 checker.
// ----------------------------------------------------------------------------
package frsck_pkg;

    // Configuration register indexes.
    localparam int unsigned CfgIdxW = 2;
    typedef logic [CfgIdxW-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_CHECK_MODE   = 2'd0;
    localparam cfg_idx_t CFG_CRC_INIT     = 2'd1;
    localparam cfg_idx_t CFG_RESULT_BYTES = 2'd2;

    // Field widths.
    localparam int unsigned ByteW  = 8;
    localparam int unsigned ValueW = 16;
    localparam int unsigned CfgW   = 16;

    // Check modes and result widths.
    localparam logic       MODE_SUM      = 1'b0;
    localparam logic       MODE_CRC      = 1'b1;
    localparam logic [1:0] RESULT_ONE_BYTE = 2'd1;
    localparam logic [1:0] RESULT_TWO_BYTES = 2'd2;

    localparam logic [ValueW-1:0] CrcPoly      = 16'hA001;
    localparam logic [ValueW-1:0] CrcInitReset = 16'hFFFF;

    // Configuration held by the top level and used by the fold logic.
    typedef struct packed {
        logic              check_mode;
        logic [ValueW-1:0] crc_init;
    } fold_cfg_t;

    // One byte of reflected CRC-16, least significant bit first.
    function automatic logic [ValueW-1:0] crc16_byte(input logic [ValueW-1:0] crc,
                                                     input logic [ByteW-1:0]  data);
        logic [ValueW-1:0] c;
        c = crc ^ {{(ValueW-ByteW){1'b0}}, data};
        for (int i = 0; i < ByteW; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CrcPoly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/core/frame_sum_or_crc16_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frame_sum_or_crc16_checker
// Byte sum or reflected CRC-16 (0xA001) over the checked range of a frame.
// A last byte's result goes from the input register through the fold logic into the result register.
// Throughput: one byte per cycle while the output is not stalled; the eight CRC shifts are combinational XOR.
// A waiting result holds the fold stage; the input register keeps taking beats
// while the fold stage moves. Reset clears the accumulator and all valids and
// loads mode CRC, init 0xFFFF and a two-byte result width.
// ----------------------------------------------------------------------------
module frame_sum_or_crc16_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [frsck_pkg::ByteW-1:0]    data_byte,
    input  logic                           first_byte,
    input  logic                           last_byte,
    // Output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [frsck_pkg::ValueW-1:0]   check_value,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [frsck_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [frsck_pkg::CfgW-1:0]     cfg_data
);
    import frsck_pkg::*;

    logic              check_mode_reg;
    logic [ValueW-1:0] crc_init_reg;
    logic [1:0]        result_bytes_reg;

    logic              s1_valid_reg, s1_valid_next;
    logic [ByteW-1:0]  s1_byte_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;

    logic [ValueW-1:0] running_value_reg;
    logic              out_valid_reg, out_valid_next;
    logic [ValueW-1:0] out_value_reg;

    logic              advance;
    logic              in_take;
    logic [ValueW-1:0] folded_value;
    logic [ValueW-1:0] masked_value;
    fold_cfg_t         fold_cfg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_mode_reg   <= MODE_CRC;
            crc_init_reg     <= CrcInitReset;
            result_bytes_reg <= RESULT_TWO_BYTES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHECK_MODE:   check_mode_reg   <= cfg_data[0];
                CFG_CRC_INIT:     crc_init_reg     <= cfg_data[ValueW-1:0];
                CFG_RESULT_BYTES: result_bytes_reg <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    // Handshake: the fold stage moves unless a result waits on a stalled output.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? (s1_valid_reg && s1_last_reg) : out_valid_reg;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg  <= data_byte;
            s1_first_reg <= first_byte;
            s1_last_reg  <= last_byte;
        end
    end

    // Fold logic between the input register and the accumulator.
    assign fold_cfg.check_mode = check_mode_reg;
    assign fold_cfg.crc_init   = crc_init_reg;

    frsck_fold u_fold (
        .cfg           (fold_cfg),
        .running_value (running_value_reg),
        .data_byte     (s1_byte_reg),
        .first_byte    (s1_first_reg),
        .folded_value  (folded_value)
    );

    // Cut the result to one byte when asked; other widths keep 16 bits.
    assign masked_value = (result_bytes_reg == RESULT_ONE_BYTE)
                        ? {{(ValueW-ByteW){1'b0}}, folded_value[ByteW-1:0]}
                        : folded_value;

    // Accumulator and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_value_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance && s1_valid_reg)
                running_value_reg <= folded_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg && s1_last_reg)
            out_value_reg <= masked_value;
    end

    assign out_valid   = out_valid_reg;
    assign check_value = out_value_reg;

endmodule
`default_nettype wire

### rtl/core/frsck_fold.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frsck_fold
// Folds one registered byte into the accumulator: a restart on the first
// mark, then either a wrapping byte add or one CRC-16 byte step.
// ----------------------------------------------------------------------------
module frsck_fold (
    input  frsck_pkg::fold_cfg_t         cfg,
    input  logic [frsck_pkg::ValueW-1:0] running_value,
    input  logic [frsck_pkg::ByteW-1:0]  data_byte,
    input  logic                         first_byte,
    output logic [frsck_pkg::ValueW-1:0] folded_value
);
    import frsck_pkg::*;

    logic [ValueW-1:0] start_value;

    // Pick the starting point: restart value on a first byte.
    always_comb
    begin
        if (first_byte)
            start_value = (cfg.check_mode == MODE_CRC) ? cfg.crc_init : '0;
        else
            start_value = running_value;
    end

    // Fold the byte in with the mode currently in force.
    always_comb
    begin
        if (cfg.check_mode == MODE_CRC)
            folded_value = crc16_byte(start_value, data_byte);
        else
            folded_value = start_value + {{(ValueW-ByteW){1'b0}}, data_byte};
    end

endmodule
`default_nettype wire
